// File: src/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; clock and reset are taken from the scope that expands them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising aclk edge outside reset
`define CPC_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("cpc port check failed");

// property checked on every rising aclk edge, reset included
`define CPC_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("cpc reset check failed");

`endif

// File: src/cpc_pkg.sv
// shared constants and types of the cartesian/polar converter
// no dependencies
`timescale 1ns / 1ps

package cpc_pkg;

    // default parameter values
    localparam int ITERATIONS_DEF  = 16;
    localparam int COORD_WIDTH_DEF = 16;

    // beat layout
    localparam int FIELD_W = 17;
    localparam int TDATA_W = 40;
    localparam int PAD_W   = TDATA_W - 2 * FIELD_W;

    // binary angle inside the datapath, 2^32 is one full turn
    localparam int ANGLE_W = 32;
    localparam int ATAN_N  = 24;

    // 1/K = 0x9b74eda8 / 2^32, split in two 16-bit halves
    localparam logic [15:0] KINV_HI = 16'd39796;
    localparam logic [15:0] KINV_LO = 16'd60840;

    // output limits
    localparam int COORD_MAX = 65535;
    localparam int COORD_MIN = -65536;
    localparam int MAG_MAX   = 65535;

    // atan(2^-i) in turns, scaled by 2^32
    localparam logic [ANGLE_W-1:0] ATAN_TURN [ATAN_N] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // per-item control carried down the pipeline
    typedef struct packed {
        logic func;   // 1 = polar to rectangular
        logic zero;   // zero vector in rectangular mode
        logic flip;   // half-turn pre-rotation to undo at the end
    } cpc_ctl_t;

endpackage

// File: src/cartesian_polar_converter.sv
// top level of the pipelined cordic cartesian/polar converter
// depends on cpc_pkg, cpc_kscale and cpc_stage
`timescale 1ns / 1ps

// Converts one beat per clock between rectangular and polar form with a fully
// unrolled cordic. tuser selects the direction: 0 takes signed (x, y) and returns
// magnitude and a 16-bit binary angle in [0, full turn); 1 takes an unsigned
// magnitude and a binary angle and returns signed (x, y). A zero vector gives
// magnitude 0 and angle 0. The pipeline takes a new beat every cycle while
// s_axis_tready is high. Its stages are one input stage, two for the gain
// multiply of the magnitude, one per micro-rotation, two for the output gain
// multiply and one output register. All stages advance together; an output
// register with one skid entry lets the pipeline keep moving while the consumer
// stalls until a result beat lands in the skid entry, then s_axis_tready drops
// until that entry drains into the output register. COORD_WIDTH sets the number
// of fraction bits (COORD_WIDTH - 8) carried below the coordinates.
module cartesian_polar_converter #(
    parameter int ITERATIONS  = cpc_pkg::ITERATIONS_DEF,
    parameter int COORD_WIDTH = cpc_pkg::COORD_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input beats
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [cpc_pkg::TDATA_W-1:0]   s_axis_tdata,  // coord_a[16:0], coord_b[33:17]
    input  logic [0:0]                    s_axis_tuser,  // func
    // result beats
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [cpc_pkg::TDATA_W-1:0]   m_axis_tdata   // out_a[16:0], out_b[33:17]
);

    localparam int FW    = cpc_pkg::FIELD_W;
    localparam int AW    = cpc_pkg::ANGLE_W;
    localparam int GUARD = COORD_WIDTH - 8;
    // datapath width: 20 integer bits of grown magnitude, sign and headroom
    localparam int XW    = COORD_WIDTH + 12;
    localparam int MAG_W = FW + GUARD;

    localparam logic signed [XW-1:0] HALF_S   = XW'((64'd1 << GUARD) >> 1);
    localparam logic [XW:0]          HALF_U   = (XW+1)'((64'd1 << GUARD) >> 1);
    localparam logic signed [XW-1:0] C_MIN    = XW'(cpc_pkg::COORD_MIN);
    localparam logic signed [XW-1:0] C_MAX    = XW'(cpc_pkg::COORD_MAX);
    localparam logic [XW:0]          M_MAX    = (XW+1)'(cpc_pkg::MAG_MAX);
    localparam logic [AW-1:0]        HALF_TURN = AW'(64'h8000_0000);
    localparam logic [AW-1:0]        ANG_HALF  = AW'(64'h0000_8000);

    // pipeline moves whenever the skid entry is free
    logic en;
    logic skid_valid_reg;
    assign en            = !skid_valid_reg;
    assign s_axis_tready = en;

    // ------------------------------------------------------------------
    // input stage: unpack, mode 0 half-turn pre-rotation, mode 1 quadrant fold
    // ------------------------------------------------------------------
    logic signed [FW-1:0] in_a, in_b;
    logic signed [FW:0]   a_ext, b_ext;
    logic                 in_func, a_neg, fold;
    cpc_pkg::cpc_ctl_t    s1_ctl_next;
    logic signed [XW-1:0] s1_x_next, s1_y_next;
    logic [AW-1:0]        s1_z_next;

    always_comb begin
        in_a    = s_axis_tdata[FW-1:0];
        in_b    = s_axis_tdata[2*FW-1:FW];
        in_func = s_axis_tuser[0];
        a_ext   = (FW+1)'(in_a);
        b_ext   = (FW+1)'(in_b);
        a_neg   = in_a[FW-1];
        // angle in [1/4, 3/4) of a turn
        fold    = in_b[15] ^ in_b[14];

        s1_ctl_next.func = in_func;
        s1_ctl_next.zero = !in_func && (in_a == '0) && (in_b == '0);
        s1_ctl_next.flip = in_func && fold;

        if (in_func) begin
            s1_x_next = '0;
            s1_y_next = '0;
            s1_z_next = {in_b[15] ^ fold, in_b[14:0], 16'h0000};
        end else begin
            s1_x_next = XW'(a_neg ? -a_ext : a_ext) <<< GUARD;
            s1_y_next = XW'(a_neg ? -b_ext : b_ext) <<< GUARD;
            s1_z_next = a_neg ? HALF_TURN : '0;
        end
    end

    logic                 s1_valid_reg, s2_valid_reg, s3_valid_reg;
    cpc_pkg::cpc_ctl_t    s1_ctl_reg, s2_ctl_reg, s3_ctl_reg;
    logic signed [XW-1:0] s1_x_reg, s2_x_reg, s3_x_reg;
    logic signed [XW-1:0] s1_y_reg, s2_y_reg, s3_y_reg;
    logic [AW-1:0]        s1_z_reg, s2_z_reg, s3_z_reg;
    logic [FW-1:0]        s1_mag_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= s_axis_tvalid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // stages two and three carry the item beside the magnitude multiply
    always_ff @(posedge aclk) begin
        if (en) begin
            s1_ctl_reg <= s1_ctl_next;
            s1_x_reg   <= s1_x_next;
            s1_y_reg   <= s1_y_next;
            s1_z_reg   <= s1_z_next;
            s1_mag_reg <= in_a;  // magnitude read as unsigned
            s2_ctl_reg <= s1_ctl_reg;
            s2_x_reg   <= s1_x_reg;
            s2_y_reg   <= s1_y_reg;
            s2_z_reg   <= s1_z_reg;
            s3_ctl_reg <= s2_ctl_reg;
            s3_x_reg   <= s2_x_reg;
            s3_y_reg   <= s2_y_reg;
            s3_z_reg   <= s2_z_reg;
        end
    end

    // mode 1 magnitude scaled by 1/K before rotating
    logic [MAG_W-1:0] pre_mag_in, pre_mag;

    assign pre_mag_in = MAG_W'(s1_mag_reg) << GUARD;

    cpc_kscale #(
        .MW (MAG_W)
    ) u_pre_scale (
        .aclk  (aclk),
        .en    (en),
        .m_in  (pre_mag_in),
        .q_out (pre_mag)
    );

    // ------------------------------------------------------------------
    // micro-rotation stages
    // ------------------------------------------------------------------
    logic                 cv [0:ITERATIONS];
    cpc_pkg::cpc_ctl_t    cc [0:ITERATIONS];
    logic signed [XW-1:0] cx [0:ITERATIONS];
    logic signed [XW-1:0] cy [0:ITERATIONS];
    logic [AW-1:0]        cz [0:ITERATIONS];

    assign cv[0] = s3_valid_reg;
    assign cc[0] = s3_ctl_reg;
    assign cx[0] = s3_ctl_reg.func ? XW'(pre_mag) : s3_x_reg;
    assign cy[0] = s3_y_reg;
    assign cz[0] = s3_z_reg;

    for (genvar i = 0; i < ITERATIONS; i++) begin : g_rot
        cpc_stage #(
            .XW    (XW),
            .SHIFT (i)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .valid_in  (cv[i]),
            .ctl_in    (cc[i]),
            .x_in      (cx[i]),
            .y_in      (cy[i]),
            .z_in      (cz[i]),
            .valid_out (cv[i+1]),
            .ctl_out   (cc[i+1]),
            .x_out     (cx[i+1]),
            .y_out     (cy[i+1]),
            .z_out     (cz[i+1])
        );
    end

    // ------------------------------------------------------------------
    // post stages: undo the fold, scale the mode 0 magnitude by 1/K
    // ------------------------------------------------------------------
    logic                 q1_valid_reg, q2_valid_reg;
    cpc_pkg::cpc_ctl_t    q1_ctl_reg, q2_ctl_reg;
    logic signed [XW-1:0] q1_x_reg, q2_x_reg;
    logic signed [XW-1:0] q1_y_reg, q2_y_reg;
    logic [AW-1:0]        q1_z_reg, q2_z_reg;
    logic [XW-1:0]        post_mag;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q1_valid_reg <= 1'b0;
            q2_valid_reg <= 1'b0;
        end else if (en) begin
            q1_valid_reg <= cv[ITERATIONS];
            q2_valid_reg <= q1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q1_ctl_reg <= cc[ITERATIONS];
            q1_x_reg   <= cc[ITERATIONS].flip ? -cx[ITERATIONS] : cx[ITERATIONS];
            q1_y_reg   <= cc[ITERATIONS].flip ? -cy[ITERATIONS] : cy[ITERATIONS];
            q1_z_reg   <= cz[ITERATIONS];
            q2_ctl_reg <= q1_ctl_reg;
            q2_x_reg   <= q1_x_reg;
            q2_y_reg   <= q1_y_reg;
            q2_z_reg   <= q1_z_reg;
        end
    end

    // final vectoring x is never negative
    cpc_kscale #(
        .MW (XW)
    ) u_post_scale (
        .aclk  (aclk),
        .en    (en),
        .m_in  (cx[ITERATIONS]),
        .q_out (post_mag)
    );

    // ------------------------------------------------------------------
    // rounding, saturation and result select
    // ------------------------------------------------------------------
    function automatic logic [FW-1:0] round_coord(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] s;
        logic signed [XW-1:0] r;
        s = v + HALF_S;
        r = s >>> GUARD;
        if (r < C_MIN) begin
            r = C_MIN;
        end else if (r > C_MAX) begin
            r = C_MAX;
        end
        return r[FW-1:0];
    endfunction

    logic [XW:0]   mag_sum, mag_r;
    logic [15:0]   mag_sat;
    logic [AW-1:0] ang_sum;
    logic [FW-1:0] fin_a, fin_b;

    always_comb begin
        mag_sum = (XW+1)'(post_mag) + HALF_U;
        mag_r   = mag_sum >> GUARD;
        mag_sat = (mag_r > M_MAX) ? 16'hFFFF : mag_r[15:0];
        // angle rounded to 16 bits, full turn wraps to zero
        ang_sum = q2_z_reg + ANG_HALF;

        if (q2_ctl_reg.zero) begin
            fin_a = '0;
            fin_b = '0;
        end else if (q2_ctl_reg.func) begin
            fin_a = round_coord(q2_x_reg);
            fin_b = round_coord(q2_y_reg);
        end else begin
            fin_a = {1'b0, mag_sat};
            fin_b = {1'b0, ang_sum[AW-1:AW-16]};
        end
    end

    // ------------------------------------------------------------------
    // output register with one skid entry
    // ------------------------------------------------------------------
    logic          m_valid_reg;
    logic [FW-1:0] m_a_reg, m_b_reg;
    logic [FW-1:0] skid_a_reg, skid_b_reg;
    logic          out_free;

    assign out_free = !m_valid_reg || m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            // skid entry drains first; the pipeline is held meanwhile
            m_valid_reg    <= skid_valid_reg || q2_valid_reg;
            skid_valid_reg <= 1'b0;
        end else if (en && q2_valid_reg) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            m_a_reg <= skid_valid_reg ? skid_a_reg : fin_a;
            m_b_reg <= skid_valid_reg ? skid_b_reg : fin_b;
        end else if (en) begin
            skid_a_reg <= fin_a;
            skid_b_reg <= fin_b;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{cpc_pkg::PAD_W{1'b0}}, m_b_reg, m_a_reg};

endmodule

// File: src/cpc_kscale.sv
// two-stage multiply by the inverse cordic gain, floor(m * 0x9b74eda8 / 2^32)
// depends on cpc_pkg
`timescale 1ns / 1ps

module cpc_kscale #(
    parameter int MW = 24
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [MW-1:0] m_in,
    output logic [MW-1:0] q_out
);

    logic [MW+15:0] phi_reg;
    logic [MW+15:0] plo_reg;
    logic [MW+16:0] sum;
    logic [MW-1:0]  q_next;
    logic [MW-1:0]  q_reg;

    // partial products against each half of the constant
    always_ff @(posedge aclk) begin
        if (en) begin
            phi_reg <= (MW+16)'(m_in) * (MW+16)'(cpc_pkg::KINV_HI);
            plo_reg <= (MW+16)'(m_in) * (MW+16)'(cpc_pkg::KINV_LO);
        end
    end

    always_comb begin
        sum    = (MW+17)'(phi_reg) + (MW+17)'(plo_reg >> 16);
        q_next = MW'(sum >> 16);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg <= q_next;
        end
    end

    assign q_out = q_reg;

endmodule

// File: src/cpc_stage.sv
// one registered cordic micro-rotation, vectoring or rotation by item mode
// depends on cpc_pkg
`timescale 1ns / 1ps

module cpc_stage #(
    parameter int XW    = 28,
    parameter int SHIFT = 0
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          valid_in,
    input  cpc_pkg::cpc_ctl_t             ctl_in,
    input  logic signed [XW-1:0]          x_in,
    input  logic signed [XW-1:0]          y_in,
    input  logic [cpc_pkg::ANGLE_W-1:0]   z_in,
    output logic                          valid_out,
    output cpc_pkg::cpc_ctl_t             ctl_out,
    output logic signed [XW-1:0]          x_out,
    output logic signed [XW-1:0]          y_out,
    output logic [cpc_pkg::ANGLE_W-1:0]   z_out
);

    localparam logic [4:0] IDX = 5'(SHIFT);
    localparam logic [cpc_pkg::ANGLE_W-1:0] STEP = cpc_pkg::ATAN_TURN[IDX];

    logic                        valid_reg;
    cpc_pkg::cpc_ctl_t           ctl_reg;
    logic signed [XW-1:0]        x_reg, x_next;
    logic signed [XW-1:0]        y_reg, y_next;
    logic [cpc_pkg::ANGLE_W-1:0] z_reg, z_next;
    logic signed [XW-1:0]        dx, dy;
    logic                        cw;

    always_comb begin
        dx = y_in >>> SHIFT;
        dy = x_in >>> SHIFT;
        // vectoring drives y to zero, rotation drives z to zero
        cw = ctl_in.func ? z_in[cpc_pkg::ANGLE_W-1] : !y_in[XW-1];
        if (cw) begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + STEP;
        end else begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - STEP;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctl_reg <= ctl_in;
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
        end
    end

    assign valid_out = valid_reg;
    assign ctl_out   = ctl_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;

endmodule

// File: src/cpc_checker.sv
// port-level checks of the cartesian/polar converter, bound to the top level
// depends on cpc_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cpc_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_axis_tready,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [cpc_pkg::TDATA_W-1:0] m_axis_tdata
);

    localparam int PAD_LO = 2 * cpc_pkg::FIELD_W;

    // result beat offered and held by the consumer
    logic out_stall;
    assign out_stall = m_axis_tvalid && !m_axis_tready;

    // a held result beat keeps its value
    `CPC_ASSERT(a_out_hold, out_stall |=> m_axis_tvalid && $stable(m_axis_tdata))

    // pad bits above the two result fields stay zero
    `CPC_ASSERT(a_out_pad, m_axis_tvalid |-> m_axis_tdata[cpc_pkg::TDATA_W-1:PAD_LO] == '0)

    // input stalls only while a result beat is waiting
    `CPC_ASSERT(a_stall_has_out, !s_axis_tready |-> m_axis_tvalid)

    // ready drops only after the consumer held a beat
    `CPC_ASSERT(a_stall_cause, $past(aresetn) && $fell(s_axis_tready) |-> $past(out_stall))

    // no result beat straight after a reset edge
    `CPC_ASSERT_ALWAYS(a_reset_clear, !aresetn |=> !m_axis_tvalid)

endmodule

bind cartesian_polar_converter cpc_checker u_cpc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
